/* design/shpd_pkg.sv */
// Shared types and constants of the sync-header packet deframer.
package shpd_pkg;

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] HEADER_OVERHEAD = 8'd3;

  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // One received byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [6:0]  position;
  } result_t;

endpackage

/* design/sync_header_packet_deframer_unit.sv */
// Top level of the sync-header packet deframer.
//
// Usage: feed received serial bytes on the byte channel (byte_valid,
// byte_stall, rx_byte). The block hunts for two 0xFF sync bytes, checks a
// length byte (payload = length - 3, must be even and non-negative) and a
// zero byte, then pairs payload bytes low byte first into 16-bit words.
// Each word leaves on the result channel (result_valid, result_stall) with
// kind 0 and its index in position. The byte after the payload is a
// checksum; the frame closes with kind 1 (accept, 8-bit sum of payload and
// checksum is zero) or kind 2 (reject), word zero, and the word count.
// Bad sync, length or zero bytes silently restart the hunt.
//
// A byte accepted into the input register passes through the frame logic
// into the result register. Throughput is one byte per cycle, sustained
// while result_stall does not hold a waiting result, set by the state update.
// A result waiting in the result register does not block the next byte
// from entering the input register; only a full pipeline backs up.
// Reset (rst, synchronous) empties both registers and returns to the hunt
// for the first sync byte. While result_stall is high the result beat holds
// and byte_stall rises once the input register is also occupied.
module sync_header_packet_deframer_unit import shpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] word,
  output logic [6:0]  position
);

  beat_t   beat;
  logic    advance;
  logic    res_valid;
  result_t res;

  // Hold the incoming byte.
  shpd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .beat       (beat)
  );

  // Advance the frame state by one byte.
  shpd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result beat for the receiver.
  shpd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .fire         (beat.valid),
    .res_valid    (res_valid),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .word         (word),
    .position     (position)
  );

endmodule

/* design/shpd_in_reg.sv */
// Input register: holds one received byte until the frame logic takes it.
module shpd_in_reg import shpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output beat_t      beat
);

  logic       held;
  logic [7:0] data;

  // Stall only while a held byte cannot move on.
  assign byte_stall = held && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!byte_stall) begin
      held <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      data <= rx_byte;
    end
  end

  assign beat.valid = held;
  assign beat.data  = data;

endmodule

/* design/shpd_frame.sv */
// Frame state machine: sync hunt, header check, word assembly and checksum.
module shpd_frame import shpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  beat_t   beat,
  input  logic    advance,
  output logic    res_valid,
  output result_t res
);

  localparam logic [2:0] ST_SYNC1 = 3'd0;
  localparam logic [2:0] ST_SYNC2 = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_LOW   = 3'd4;
  localparam logic [2:0] ST_HIGH  = 3'd5;

  logic [2:0] stage, stage_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] low_byte, low_byte_next;
  logic [6:0] word_index, word_index_next;
  logic [7:0] sum_add;
  logic [7:0] payload_len;
  logic       fire;

  assign fire        = beat.valid && advance;
  assign sum_add     = running_sum + beat.data;
  assign payload_len = beat.data - HEADER_OVERHEAD;

  always_comb begin
    stage_next       = stage;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    low_byte_next    = low_byte;
    word_index_next  = word_index;
    res_valid        = 1'b0;
    res.kind         = KIND_WORD;
    res.word         = 16'd0;
    res.position     = word_index;
    unique case (stage)
      ST_SYNC1: stage_next = (beat.data == SYNC_BYTE) ? ST_SYNC2 : ST_SYNC1;
      ST_SYNC2: stage_next = (beat.data == SYNC_BYTE) ? ST_LEN : ST_SYNC1;
      ST_LEN: begin
        // Drop short lengths and odd payloads without a result.
        if (beat.data < HEADER_OVERHEAD || payload_len[0]) begin
          stage_next = ST_SYNC1;
        end else begin
          bytes_left_next = payload_len;
          stage_next      = ST_ZERO;
        end
      end
      ST_ZERO: stage_next = (beat.data == 8'd0) ? ST_LOW : ST_SYNC1;
      ST_LOW: begin
        if (bytes_left == 8'd0) begin
          // Checksum byte closes the frame.
          res_valid        = 1'b1;
          res.kind         = (sum_add == 8'd0) ? KIND_ACCEPT : KIND_REJECT;
          running_sum_next = 8'd0;
          word_index_next  = 7'd0;
          stage_next       = ST_SYNC1;
        end else begin
          running_sum_next = sum_add;
          low_byte_next    = beat.data;
          stage_next       = ST_HIGH;
        end
      end
      ST_HIGH: begin
        res_valid        = 1'b1;
        res.word         = {beat.data, low_byte};
        running_sum_next = sum_add;
        bytes_left_next  = bytes_left - 8'd2;
        word_index_next  = word_index + 7'd1;
        stage_next       = ST_LOW;
      end
      default: stage_next = ST_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ST_SYNC1;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
      low_byte    <= 8'd0;
      word_index  <= 7'd0;
    end else if (fire) begin
      stage       <= stage_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      low_byte    <= low_byte_next;
      word_index  <= word_index_next;
    end
  end

endmodule

/* design/shpd_out_reg.sv */
// Result register: holds one result beat until the receiver takes it.
module shpd_out_reg import shpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        res_valid,
  input  result_t     res,
  output logic        advance,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [15:0] word,
  output logic [6:0]  position
);

  logic    held;
  result_t data;

  // Advance whenever the register is empty or being drained.
  assign advance = !held || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (advance) begin
      held <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      data <= res;
    end
  end

  assign result_valid = held;
  assign kind         = data.kind;
  assign word         = data.word;
  assign position     = data.position;

endmodule

/* test/tb_sync_header_packet_deframer_unit.sv */
// Self-checking testbench for the sync-header packet deframer: byte driver, result monitor, predictor.
module tb_sync_header_packet_deframer_unit;
  import shpd_pkg::*;

  // Frame hunt stages of the predictor.
  typedef enum logic [2:0] {
    ST_HUNT1  = 3'd0,
    ST_HUNT2  = 3'd1,
    ST_LENGTH = 3'd2,
    ST_ZERO   = 3'd3,
    ST_LOW    = 3'd4,
    ST_HIGH   = 3'd5
  } hunt_stage_t;

  localparam int STREAM_BYTES  = 1200;
  localparam int QUIET_TAIL    = 150;   // last bytes sent with no idling on either side
  localparam int LONG_HOLD     = 80;    // cycles of the long receiver hold-off
  localparam int HOLD_AT       = 100;   // results seen before the long hold-off starts
  localparam int WATCHDOG_MAX  = 2000;  // cycles with no beat on either channel
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_MAX    = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] word;
  logic [6:0]  position;

  sync_header_packet_deframer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .word         (word),
    .position     (position)
  );

  always #6 clk = ~clk;

  // Bytes still to be offered, and results the predictor says are due.
  logic [7:0] rx_stream[$];
  result_t    frame_results_due[$];

  // Predictor copy of the deframer state.
  hunt_stage_t frm_stage = ST_HUNT1;
  logic [7:0]  frm_left  = 8'd0;
  logic [7:0]  frm_sum   = 8'd0;
  logic [7:0]  frm_low   = 8'd0;
  logic [6:0]  frm_words = 7'd0;

  int  error_count   = 0;
  int  results_seen  = 0;
  int  idle_cycles   = 0;
  int  idle_level    = 0;   // 0..3, chance of starting an idle burst, redrawn in the idle-rate phases
  int  cycle_count   = 0;
  bit  quiet         = 1'b0;
  bit  timed_out     = 1'b0;

  // Advance the predictor by one accepted byte; queue any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] payload;
    r = '0;
    payload = b - HEADER_OVERHEAD;
    case (frm_stage)
      ST_HUNT1: frm_stage = (b == SYNC_BYTE) ? ST_HUNT2 : ST_HUNT1;
      ST_HUNT2: frm_stage = (b == SYNC_BYTE) ? ST_LENGTH : ST_HUNT1;
      ST_LENGTH: begin
        // Drop the frame silently on a short length or an odd payload.
        if (b < HEADER_OVERHEAD || payload[0]) begin
          frm_stage = ST_HUNT1;
        end else begin
          frm_left  = payload;
          frm_stage = ST_ZERO;
        end
      end
      ST_ZERO: frm_stage = (b == 8'h00) ? ST_LOW : ST_HUNT1;
      ST_LOW: begin
        frm_sum = frm_sum + b;
        if (frm_left == 8'd0) begin
          // Checksum byte: close the frame with its verdict and word count.
          r.kind     = (frm_sum == 8'd0) ? KIND_ACCEPT : KIND_REJECT;
          r.position = frm_words;
          frame_results_due.push_back(r);
          frm_sum   = 8'd0;
          frm_words = 7'd0;
          frm_stage = ST_HUNT1;
        end else begin
          frm_low   = b;
          frm_stage = ST_HIGH;
        end
      end
      ST_HIGH: begin
        frm_sum    = frm_sum + b;
        r.kind     = KIND_WORD;
        r.word     = {b, frm_low};
        r.position = frm_words;
        frame_results_due.push_back(r);
        frm_left  = frm_left - 8'd2;
        frm_words = frm_words + 7'd1;
        frm_stage = ST_LOW;
      end
      default: frm_stage = ST_HUNT1;
    endcase
  endtask

  // Queue one frame of the given word count; spoil the checksum unless asked not to.
  task automatic queue_frame(input int n_words, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    rx_stream.push_back(SYNC_BYTE);
    rx_stream.push_back(SYNC_BYTE);
    rx_stream.push_back(8'(2 * n_words + 3));
    rx_stream.push_back(8'h00);
    for (int i = 0; i < 2 * n_words; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      rx_stream.push_back(b);
    end
    if (good_sum) rx_stream.push_back(8'h00 - sum);
    else rx_stream.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int pick;
    int n;
    // Directed part: bad second sync, length below the header size, odd payload,
    // nonzero byte after the length, an empty frame with a bad checksum, and a
    // one-word frame of all-ones bytes that closes with a good checksum.
    rx_stream = '{8'hFF, 8'h12,
                  8'hFF, 8'hFF, 8'h02,
                  8'hFF, 8'hFF, 8'h04,
                  8'hFF, 8'hFF, 8'h03, 8'h07,
                  8'hFF, 8'hFF, 8'h03, 8'h00, 8'h01,
                  8'hFF, 8'hFF, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'h02};
    // Random part: mostly well-formed frames of small size, a few of the
    // largest size, the rest line noise and broken headers.
    while (rx_stream.size() < STREAM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        n = ($urandom_range(0, 39) == 0) ? 126 : $urandom_range(0, 8);
        queue_frame(n, $urandom_range(0, 2) != 0);
      end else if (pick < 84) begin
        n = $urandom_range(1, 6);
        repeat (n) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        // Any length byte at all, then a zero byte and a little payload.
        rx_stream.push_back(SYNC_BYTE);
        rx_stream.push_back(SYNC_BYTE);
        rx_stream.push_back(8'($urandom_range(0, 255)));
        rx_stream.push_back(8'h00);
        n = $urandom_range(0, 4);
        repeat (n) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Good length followed by a nonzero byte.
        rx_stream.push_back(SYNC_BYTE);
        rx_stream.push_back(SYNC_BYTE);
        rx_stream.push_back(8'(2 * $urandom_range(0, 8) + 3));
        rx_stream.push_back(8'($urandom_range(1, 255)));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        wait (rx_stream.size() == 0 && !byte_valid && frame_results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_MAX);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && error_count == 0 && frame_results_due.size() == 0) begin
      $display("tb_sync_header_packet_deframer_unit passed");
    end else begin
      $display("tb_sync_header_packet_deframer_unit failed");
    end
    $finish;
  end

  // Byte driver: hold a stalled beat, otherwise advance to the next byte or idle.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) deframe_byte(rx_byte);
      if (!byte_valid || !byte_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_valid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          byte_valid <= 1'b1;
          rx_byte    <= rx_stream.pop_front();
          if (!quiet && $urandom_range(0, 9) < idle_level) send_gap = $urandom_range(1, 7);
        end else begin
          byte_valid <= 1'b0;
        end
      end
      quiet <= (rx_stream.size() < QUIET_TAIL);
    end
  end

  // Result monitor: check each accepted beat, then pick the stall for the next cycle.
  int stall_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (frame_results_due.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected result: kind %0d word %h position %0d",
                     kind, word, position);
        end else begin
          result_t exp_r;
          exp_r = frame_results_due.pop_front();
          if (kind !== exp_r.kind || word !== exp_r.word || position !== exp_r.position) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("result mismatch: expected kind %0d word %h position %0d, got kind %0d word %h position %0d",
                       exp_r.kind, exp_r.word, exp_r.position, kind, word, position);
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input.
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        result_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) < idle_level) begin
        stall_gap = $urandom_range(0, 6);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog and idle-rate phases.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 64 == 0) idle_level = $urandom_range(0, 3);
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

endmodule

/* sync_header_packet_deframer_unit.f */
design/shpd_pkg.sv
design/shpd_in_reg.sv
design/shpd_frame.sv
design/shpd_out_reg.sv
design/sync_header_packet_deframer_unit.sv
test/tb_sync_header_packet_deframer_unit.sv
